>>> hdl/tvf_pkg.sv
// shared types and constants of the tsdf voxel fusion unit
package tvf_pkg;

   localparam int VOXEL_COUNT = 2097152;
   localparam int MEM_AW      = $clog2(VOXEL_COUNT);

   localparam logic [15:0]        DELTA_RESET  = 16'd50;
   localparam logic signed [15:0] DIST_RESET   = -16'sd32767;
   localparam logic [7:0]         COLOUR_RESET = 8'd127;
   localparam logic [15:0]        WEIGHT_MAX   = 16'hFFFF;
   localparam logic [31:0]        DIST_SCALE   = 32'd32767;

   typedef struct packed {
      logic signed [15:0] tsd;
      logic [15:0]        dw;
      logic [15:0]        cw;
      logic [7:0]         r;
      logic [7:0]         g;
      logic [7:0]         b;
   } voxel_type;

   localparam voxel_type VOXEL_RESET = '{
      tsd: DIST_RESET, dw: 16'd0, cw: 16'd0,
      r: COLOUR_RESET, g: COLOUR_RESET, b: COLOUR_RESET};

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [MEM_AW-1:0]   addr;
      voxel_type           wdata;
   } mem_req_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [16:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quo;
   } div_rsp_type;

endpackage

>>> hdl/tvf_ram.sv
// generic single-port ram with registered read
module tvf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/tvf_div.sv
// iterative restoring divider, one quotient bit per cycle
module tvf_div
   import tvf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] num_ff;
   logic [31:0] quo_ff;
   logic [17:0] rem_ff;
   logic [16:0] den_ff;
   logic [17:0] rem_sh_in;
   logic        fits_in;

   assign rem_sh_in = {rem_ff[16:0], num_ff[31]};
   assign fits_in   = rem_sh_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (req.start) begin
         num_ff <= req.num;
         den_ff <= req.den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[30:0], 1'b0};
         rem_ff <= fits_in ? rem_sh_in - {1'b0, den_ff} : rem_sh_in;
         quo_ff <= {quo_ff[30:0], fits_in};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

>>> hdl/tvf_ctrl.sv
// update sequencer: clear pass, read, divide steps, write back
module tvf_ctrl
   import tvf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [20:0]        req_voxel_address,
   input  logic signed [16:0] req_voxel_depth,
   input  logic [15:0]        req_measured_depth,
   input  logic               req_in_view,
   input  logic [7:0]         req_pixel_red,
   input  logic [7:0]         req_pixel_green,
   input  logic [7:0]         req_pixel_blue,
   input  logic [15:0]        delta,
   output mem_req_type        mem_req,
   input  voxel_type          mem_rdata,
   output div_req_type        div_req,
   input  div_rsp_type        div_rsp,
   output logic               rsp_valid,
   output logic [20:0]        rsp_voxel_index_out,
   output logic               rsp_was_updated,
   output logic signed [15:0] rsp_distance_value,
   output logic [15:0]        rsp_distance_weight,
   output logic [7:0]         rsp_red_out,
   output logic [7:0]         rsp_green_out,
   output logic [7:0]         rsp_blue_out
);

   typedef enum logic [3:0] {
      CLEAR, IDLE, LOAD, DIV_T, DIST, DIV_D, COLOUR, DIV_R, DIV_G, DIV_B, FINISH
   } state_type;

   localparam logic [MEM_AW-1:0] LAST_ADDR = MEM_AW'(VOXEL_COUNT - 1);

   state_type          state_ff;
   logic [MEM_AW-1:0]  clr_ff;
   logic [20:0]        addr_ff;
   logic signed [16:0] vdepth_ff;
   logic [15:0]        mdepth_ff;
   logic               view_ff;
   logic [7:0]         pr_ff, pg_ff, pb_ff;
   logic [15:0]        delta_ff;
   logic               in_range_ff;
   logic               active_ff;
   logic               near_ff;
   logic               t_neg_ff;
   logic signed [32:0] prod_ff;
   logic signed [15:0] tq_ff;
   voxel_type          old_ff;
   voxel_type          new_ff;
   logic               div_start_ff;
   logic [31:0]        div_num_ff;
   logic [16:0]        div_den_ff;

   logic signed [17:0] sdf_in, delta_s_in, t_in;
   logic [16:0]        abs_t_in;
   logic               active_in;
   logic [31:0]        num_t_in;
   logic signed [15:0] tq_in;
   logic signed [32:0] sum_d_in;
   logic [31:0]        mag_d_in;
   logic [16:0]        den_d_in;
   logic [16:0]        den_c_in;
   logic [31:0]        num_r_in, num_g_in, num_b_in;
   logic [15:0]        quo_lo_in;

   // load-state arithmetic on the registered request word
   always_comb begin
      delta_s_in = $signed({2'b00, delta_ff});
      sdf_in     = $signed({vdepth_ff[16], vdepth_ff}) - $signed({2'b00, mdepth_ff});
      if (sdf_in > delta_s_in) begin
         t_in = delta_s_in;
      end else if (sdf_in < -delta_s_in) begin
         t_in = -delta_s_in;
      end else begin
         t_in = sdf_in;
      end
      abs_t_in  = t_in[17] ? 17'(-t_in) : 17'(t_in);
      num_t_in  = {15'd0, abs_t_in} * DIST_SCALE + {17'd0, delta_ff[15:1]};
      active_in = (vdepth_ff > 17'sd0) && view_ff && (mdepth_ff != 16'd0) && in_range_ff;
   end

   assign quo_lo_in = div_rsp.quo[15:0];
   assign tq_in     = t_neg_ff ? -$signed(quo_lo_in) : $signed(quo_lo_in);

   always_comb begin
      sum_d_in = prod_ff + 33'($signed(tq_ff));
      mag_d_in = sum_d_in[32] ? 32'(-sum_d_in) : 32'(sum_d_in);
      den_d_in = {1'b0, old_ff.dw} + 17'd1;
      den_c_in = {1'b0, old_ff.cw} + 17'd1;
      num_r_in = 32'(old_ff.r) * 32'(old_ff.cw) + 32'(pr_ff);
      num_g_in = 32'(old_ff.g) * 32'(old_ff.cw) + 32'(pg_ff);
      num_b_in = 32'(old_ff.b) * 32'(old_ff.cw) + 32'(pb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         clr_ff       <= '0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         case (state_ff)
            CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= IDLE;
               end
            end
            IDLE: begin
               if (start) begin
                  addr_ff     <= req_voxel_address;
                  vdepth_ff   <= req_voxel_depth;
                  mdepth_ff   <= req_measured_depth;
                  view_ff     <= req_in_view;
                  pr_ff       <= req_pixel_red;
                  pg_ff       <= req_pixel_green;
                  pb_ff       <= req_pixel_blue;
                  delta_ff    <= (delta == 16'd0) ? 16'd1 : delta;
                  in_range_ff <= 32'(req_voxel_address) < 32'(VOXEL_COUNT);
                  state_ff    <= LOAD;
               end
            end
            LOAD: begin
               old_ff    <= mem_rdata;
               new_ff    <= in_range_ff ? mem_rdata : '0;
               active_ff <= active_in;
               near_ff   <= sdf_in <= delta_s_in;
               t_neg_ff  <= t_in[17];
               prod_ff   <= mem_rdata.tsd * $signed({1'b0, mem_rdata.dw});
               if (active_in) begin
                  div_start_ff <= 1'b1;
                  div_num_ff   <= num_t_in;
                  div_den_ff   <= {1'b0, delta_ff};
                  state_ff     <= DIV_T;
               end else begin
                  state_ff <= FINISH;
               end
            end
            DIV_T: begin
               if (div_rsp.done) begin
                  tq_ff    <= tq_in;
                  state_ff <= near_ff ? DIST : COLOUR;
               end
            end
            DIST: begin
               // distance numerator is only formed once tq is known
               div_start_ff <= 1'b1;
               div_num_ff   <= mag_d_in + {16'd0, den_d_in[16:1]};
               div_den_ff   <= den_d_in;
               state_ff     <= DIV_D;
            end
            DIV_D: begin
               if (div_rsp.done) begin
                  new_ff.tsd <= sum_d_in[32] ? -$signed(quo_lo_in) : $signed(quo_lo_in);
                  new_ff.dw  <= (old_ff.dw == WEIGHT_MAX) ? WEIGHT_MAX : old_ff.dw + 16'd1;
                  state_ff   <= COLOUR;
               end
            end
            COLOUR: begin
               if (old_ff.cw == 16'd0) begin
                  new_ff.r  <= pr_ff;
                  new_ff.g  <= pg_ff;
                  new_ff.b  <= pb_ff;
                  new_ff.cw <= near_ff ? 16'd1 : 16'd0;
                  state_ff  <= FINISH;
               end else if (near_ff) begin
                  div_start_ff <= 1'b1;
                  div_num_ff   <= num_r_in;
                  div_den_ff   <= den_c_in;
                  state_ff     <= DIV_R;
               end else begin
                  state_ff <= FINISH;
               end
            end
            DIV_R: begin
               if (div_rsp.done) begin
                  new_ff.r     <= div_rsp.quo[7:0];
                  div_start_ff <= 1'b1;
                  div_num_ff   <= num_g_in;
                  state_ff     <= DIV_G;
               end
            end
            DIV_G: begin
               if (div_rsp.done) begin
                  new_ff.g     <= div_rsp.quo[7:0];
                  div_start_ff <= 1'b1;
                  div_num_ff   <= num_b_in;
                  state_ff     <= DIV_B;
               end
            end
            DIV_B: begin
               if (div_rsp.done) begin
                  new_ff.b  <= div_rsp.quo[7:0];
                  new_ff.cw <= (old_ff.cw == WEIGHT_MAX) ? WEIGHT_MAX : old_ff.cw + 16'd1;
                  state_ff  <= FINISH;
               end
            end
            FINISH: begin
               state_ff <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   always_comb begin
      mem_req.rd_en = 1'b0;
      mem_req.wr_en = 1'b0;
      mem_req.addr  = MEM_AW'(addr_ff);
      mem_req.wdata = new_ff;
      case (state_ff)
         CLEAR: begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = clr_ff;
            mem_req.wdata = VOXEL_RESET;
         end
         IDLE: begin
            mem_req.rd_en = start;
            mem_req.addr  = MEM_AW'(req_voxel_address);
         end
         FINISH: begin
            mem_req.wr_en = active_ff;
         end
         default: begin
            mem_req.wr_en = 1'b0;
         end
      endcase
   end

   assign div_req.start = div_start_ff;
   assign div_req.num   = div_num_ff;
   assign div_req.den   = div_den_ff;

   assign busy                = state_ff != IDLE;
   assign rsp_valid           = state_ff == FINISH;
   assign rsp_voxel_index_out = addr_ff;
   assign rsp_was_updated     = active_ff && (new_ff != old_ff);
   assign rsp_distance_value  = new_ff.tsd;
   assign rsp_distance_weight = new_ff.dw;
   assign rsp_red_out         = new_ff.r;
   assign rsp_green_out       = new_ff.g;
   assign rsp_blue_out        = new_ff.b;

endmodule

>>> hdl/tsdf_voxel_fusion_unit.sv
// top level of the tsdf voxel fusion unit
// One voxel update at a time: raise start while busy is low and the word is taken. After
// reset the unit sweeps the voxel memory once to its reset contents, one entry per cycle,
// with busy high. How long an update runs from one accepted word to the next depends on
// the divisions it needs from the shared one-bit-per-cycle divider: none for a skipped
// voxel, one for a voxel outside the truncation band, two for a voxel in the band without
// colour history and five for a voxel in the band with colour history. The result word
// appears for one cycle with rsp_valid and cannot be held off; busy drops in the following
// cycle. Write csr_wr_en only while busy is low.
module tsdf_voxel_fusion_unit
   import tvf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [20:0]        req_voxel_address,
   input  logic signed [16:0] req_voxel_depth,
   input  logic [15:0]        req_measured_depth,
   input  logic               req_in_view,
   input  logic [7:0]         req_pixel_red,
   input  logic [7:0]         req_pixel_green,
   input  logic [7:0]         req_pixel_blue,
   output logic               rsp_valid,
   output logic [20:0]        rsp_voxel_index_out,
   output logic               rsp_was_updated,
   output logic signed [15:0] rsp_distance_value,
   output logic [15:0]        rsp_distance_weight,
   output logic [7:0]         rsp_red_out,
   output logic [7:0]         rsp_green_out,
   output logic [7:0]         rsp_blue_out,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic [15:0] delta_ff;
   mem_req_type mem_req;
   voxel_type   mem_rdata;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= DELTA_RESET;
      end else if (csr_wr_en) begin
         delta_ff <= csr_wr_data;
      end
   end

   tvf_ram #(
      .WIDTH ($bits(voxel_type)),
      .DEPTH (VOXEL_COUNT)
   ) u_ram (
      .clock (clock),
      .rd_en (mem_req.rd_en),
      .wr_en (mem_req.wr_en),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   tvf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tvf_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_voxel_address   (req_voxel_address),
      .req_voxel_depth     (req_voxel_depth),
      .req_measured_depth  (req_measured_depth),
      .req_in_view         (req_in_view),
      .req_pixel_red       (req_pixel_red),
      .req_pixel_green     (req_pixel_green),
      .req_pixel_blue      (req_pixel_blue),
      .delta               (delta_ff),
      .mem_req             (mem_req),
      .mem_rdata           (mem_rdata),
      .div_req             (div_req),
      .div_rsp             (div_rsp),
      .rsp_valid           (rsp_valid),
      .rsp_voxel_index_out (rsp_voxel_index_out),
      .rsp_was_updated     (rsp_was_updated),
      .rsp_distance_value  (rsp_distance_value),
      .rsp_distance_weight (rsp_distance_weight),
      .rsp_red_out         (rsp_red_out),
      .rsp_green_out       (rsp_green_out),
      .rsp_blue_out        (rsp_blue_out)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word did not raise busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after result");
   a_no_write_on_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy) |-> !mem_req.wr_en) else $error("memory write while idle");
`endif

endmodule

>>> bench/tsdf_voxel_fusion_unit_tb.sv
// self-checking testbench of the tsdf voxel fusion unit with a scoreboard and a voxel predictor
`timescale 1ns / 1ps

module tsdf_voxel_fusion_unit_tb;
   import tvf_pkg::*;

   localparam longint CYCLE_LIMIT = 64'd4 * (64'd2097152 + 64'd400000);
   localparam int     DRAIN_CYCLES = 250;

   typedef struct {
      logic [20:0]        addr;
      logic               upd;
      logic signed [15:0] tsd;
      logic [15:0]        dw;
      logic [7:0]         r;
      logic [7:0]         g;
      logic [7:0]         b;
   } fused_word_type;

   class fusion_scoreboard;
      voxel_type      voxel_mem[int];
      fused_word_type pending_words[$];
      logic [15:0]    band_mm;
      int             errors;

      function new();
         band_mm = DELTA_RESET;
         errors  = 0;
      endfunction

      function longint round_div(longint num, longint den);
         if (num >= 0) return (num + den / 2) / den;
         return -((-num + den / 2) / den);
      endfunction

      task report(string what, longint got, longint want, logic [20:0] addr);
         $display("mismatch %s at voxel %0d: got %0d want %0d", what, addr, got, want);
         errors++;
      endtask

      function void note_word(logic [20:0] addr, logic signed [16:0] vdepth,
                              logic [15:0] mdepth, logic view,
                              logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
         voxel_type      vx;
         fused_word_type w;
         longint         delta, sdf, t, tq, nd, cw;
         logic [7:0]     nr, ng, nb;
         logic [15:0]    ncw, nw;
         logic           near;
         w.addr = addr;
         w.upd  = 1'b0;
         vx = voxel_mem.exists(addr) ? voxel_mem[addr] : VOXEL_RESET;
         if (vdepth > 0 && view && mdepth != 0) begin
            delta = (band_mm != 0) ? longint'(band_mm) : 1;
            sdf   = longint'(vdepth) - longint'(mdepth);
            t     = sdf > delta ? delta : (sdf < -delta ? -delta : sdf);
            tq    = round_div(t * 32767, delta);
            near  = sdf <= delta;
            cw    = vx.cw;
            if (near) begin
               nd = round_div(longint'(vx.tsd) * longint'(vx.dw) + tq, longint'(vx.dw) + 1);
               nw = (vx.dw == WEIGHT_MAX) ? WEIGHT_MAX : vx.dw + 16'd1;
               if (nd != longint'(vx.tsd) || nw != vx.dw) w.upd = 1'b1;
               vx.tsd = 16'(nd);
               vx.dw  = nw;
            end
            if (near || cw == 0) begin
               if (cw == 0) begin
                  nr = pr; ng = pg; nb = pb;
                  ncw = near ? 16'd1 : 16'd0;
               end else begin
                  nr  = 8'((longint'(vx.r) * cw + pr) / (cw + 1));
                  ng  = 8'((longint'(vx.g) * cw + pg) / (cw + 1));
                  nb  = 8'((longint'(vx.b) * cw + pb) / (cw + 1));
                  ncw = (vx.cw == WEIGHT_MAX) ? WEIGHT_MAX : vx.cw + 16'd1;
               end
               if (nr != vx.r || ng != vx.g || nb != vx.b || ncw != vx.cw) w.upd = 1'b1;
               vx.r = nr; vx.g = ng; vx.b = nb; vx.cw = ncw;
            end
            voxel_mem[addr] = vx;
         end
         w.tsd = vx.tsd; w.dw = vx.dw; w.r = vx.r; w.g = vx.g; w.b = vx.b;
         pending_words.push_back(w);
      endfunction

      task check_word(fused_word_type got);
         fused_word_type want;
         if (pending_words.size() == 0) begin
            $display("unexpected word for voxel %0d", got.addr);
            errors++;
         end else begin
            want = pending_words.pop_front();
            if (got.addr !== want.addr) report("index", got.addr, want.addr, want.addr);
            if (got.upd !== want.upd) report("updated", got.upd, want.upd, want.addr);
            if (got.tsd !== want.tsd) report("distance", got.tsd, want.tsd, want.addr);
            if (got.dw !== want.dw) report("weight", got.dw, want.dw, want.addr);
            if (got.r !== want.r) report("red", got.r, want.r, want.addr);
            if (got.g !== want.g) report("green", got.g, want.g, want.addr);
            if (got.b !== want.b) report("blue", got.b, want.b, want.addr);
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [20:0]        req_voxel_address = '0;
   logic signed [16:0] req_voxel_depth = '0;
   logic [15:0]        req_measured_depth = '0;
   logic               req_in_view = 1'b0;
   logic [7:0]         req_pixel_red = '0;
   logic [7:0]         req_pixel_green = '0;
   logic [7:0]         req_pixel_blue = '0;
   logic               rsp_valid;
   logic [20:0]        rsp_voxel_index_out;
   logic               rsp_was_updated;
   logic signed [15:0] rsp_distance_value;
   logic [15:0]        rsp_distance_weight;
   logic [7:0]         rsp_red_out;
   logic [7:0]         rsp_green_out;
   logic [7:0]         rsp_blue_out;
   logic               csr_wr_en = 1'b0;
   logic [15:0]        csr_wr_data = '0;

   fusion_scoreboard sb = new();
   longint           cycle_count = 0;
   logic [20:0]      hot_voxels[16];

   tsdf_voxel_fusion_unit DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      fused_word_type got;
      if (!reset && rsp_valid) begin
         got.addr = rsp_voxel_index_out;
         got.upd  = rsp_was_updated;
         got.tsd  = rsp_distance_value;
         got.dw   = rsp_distance_weight;
         got.r    = rsp_red_out;
         got.g    = rsp_green_out;
         got.b    = rsp_blue_out;
         sb.check_word(got);
      end
   end

   // start stays high across back-to-back words; lowered for an idle burst, a band write and the final drain
   task send_voxel(logic [20:0] addr, logic signed [16:0] vdepth, logic [15:0] mdepth,
                   logic view, logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
      req_voxel_address  <= addr;
      req_voxel_depth    <= vdepth;
      req_measured_depth <= mdepth;
      req_in_view        <= view;
      req_pixel_red      <= pr;
      req_pixel_green    <= pg;
      req_pixel_blue     <= pb;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_word(addr, vdepth, mdepth, view, pr, pg, pb);
   endtask

   task idle_burst(bit allow);
      if (allow && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task write_band(logic [15:0] value);
      start <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.band_mm = value;
   endtask

   task random_voxel(bit allow_idle);
      logic [20:0]  addr;
      logic [15:0]  mdepth;
      longint       delta, vd;
      delta = (sb.band_mm != 0) ? sb.band_mm : 1;
      addr = ($urandom_range(0, 9) < 8) ? hot_voxels[$urandom_range(0, 15)]
                                         : 21'($urandom);
      if ($urandom_range(0, 9) < 8) begin
         mdepth = 16'($urandom_range(1, 65535));
         vd = longint'(mdepth) + longint'($urandom_range(0, 4 * delta + 2)) - 2 * delta - 1;
         if (vd > 65535) vd = 65535;
         if (vd < -65536) vd = -65536;
         send_voxel(addr, 17'(vd), mdepth, ($urandom_range(0, 15) != 0),
                    8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         send_voxel(addr, 17'($urandom), 16'($urandom), 1'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
      end
      idle_burst(allow_idle);
   endtask

   initial begin
      logic [15:0] bands[5];
      foreach (hot_voxels[i]) hot_voxels[i] = 21'($urandom);
      hot_voxels[0] = 21'd0;
      hot_voxels[1] = 21'h1FFFFF;
      bands = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 2000)), DELTA_RESET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: skips, band edges, fresh and repeated voxels, colour extremes
      send_voxel(21'd0, -17'sd65536, 16'd100, 1'b1, 8'd255, 8'd255, 8'd255);
      send_voxel(21'd0, 17'sd0, 16'd100, 1'b1, 8'd0, 8'd0, 8'd0);
      send_voxel(21'd0, 17'sd100, 16'd0, 1'b1, 8'd1, 8'd2, 8'd3);
      send_voxel(21'd0, 17'sd100, 16'd100, 1'b0, 8'd4, 8'd5, 8'd6);
      send_voxel(21'd5, 17'sd200, 16'd100, 1'b1, 8'd10, 8'd20, 8'd30);
      send_voxel(21'd5, 17'sd150, 16'd100, 1'b1, 8'd255, 8'd0, 8'd128);
      send_voxel(21'd5, 17'sd151, 16'd100, 1'b1, 8'd0, 8'd0, 8'd0);
      send_voxel(21'd5, 17'sd50, 16'd100, 1'b1, 8'd0, 8'd255, 8'd7);
      send_voxel(21'd5, 17'sd1, 16'd65535, 1'b1, 8'd255, 8'd255, 8'd255);
      send_voxel(21'd5, 17'sd65535, 16'd65535, 1'b1, 8'd0, 8'd0, 8'd0);
      send_voxel(21'h1FFFFF, 17'sd65535, 16'd1, 1'b1, 8'd9, 8'd9, 8'd9);
      send_voxel(21'h1FFFFF, 17'sd1, 16'd1, 1'b1, 8'd255, 8'd255, 8'd255);
      send_voxel(21'h1FFFFF, 17'sd1, 16'd1, 1'b1, 8'd255, 8'd255, 8'd255);
      send_voxel(21'h0AAAAA, 17'sd30, 16'd55, 1'b1, 8'd17, 8'd34, 8'd51);
      send_voxel(21'h155555, 17'sd30, 16'd80, 1'b1, 8'd200, 8'd100, 8'd50);
      send_voxel(21'h0AAAAA, 17'sd70, 16'd55, 1'b1, 8'd1, 8'd1, 8'd1);

      foreach (bands[p]) begin
         write_band(bands[p]);
         if (p == 0) begin
            // zero band acts as one
            send_voxel(21'd9, 17'sd101, 16'd100, 1'b1, 8'd3, 8'd3, 8'd3);
            send_voxel(21'd9, 17'sd100, 16'd100, 1'b1, 8'd6, 8'd6, 8'd6);
            send_voxel(21'd9, 17'sd99, 16'd100, 1'b1, 8'd9, 8'd9, 8'd9);
         end
         repeat (305) random_voxel(p != 4);
      end

      start <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_words.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
hdl/tvf_pkg.sv
hdl/tvf_ram.sv
hdl/tvf_div.sv
hdl/tvf_ctrl.sv
hdl/tsdf_voxel_fusion_unit.sv
bench/tsdf_voxel_fusion_unit_tb.sv
